FILE: src/btop_pkg.sv
// btop_pkg: shared types and constants for the binomial tree option pricer
// used by btop_ctrl, btop_dp and binomial_tree_option_pricer
`timescale 1ns / 1ps

package btop_pkg;

    localparam logic [31:0] Q30_ONE  = 32'h4000_0000;
    localparam logic [31:0] Q16_ONE  = 32'h0001_0000;
    localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;

    // register indexes
    localparam logic [2:0] REG_UP   = 3'd0;
    localparam logic [2:0] REG_DOWN = 3'd1;
    localparam logic [2:0] REG_PROB = 3'd2;
    localparam logic [2:0] REG_DISC = 3'd3;
    localparam logic [2:0] REG_STEP = 3'd4;

    // multiplier operand select
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_DOWN,
        OP_UP,
        OP_MIX_P,
        OP_MIX_Q,
        OP_DISC
    } mul_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic    load_item;
        logic    load_price;
        mul_op_t op;
        logic    price_wr;
        logic    payoff_wr;
        logic    rd_en;
        logic    fold_wr;
        logic    mix_add;
        logic    done;
    } btop_cmd_t;

endpackage

FILE: src/btop_ram.sv
// btop_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps

module btop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/btop_dp.sv
// btop_dp: datapath with one shared 32x32 multiplier, node price and mix accumulator
// depends on btop_pkg and btop_ram
`timescale 1ns / 1ps

module btop_dp #(
    parameter int MAX_STEPS = 64,
    localparam int AW = $clog2(MAX_STEPS + 1)
) (
    input  logic                 clk,
    input  btop_pkg::btop_cmd_t  cmd,
    input  logic [AW-1:0]        wr_addr,
    input  logic [AW-1:0]        rd_addr,
    input  logic [31:0]          spot_price,
    input  logic [31:0]          strike_price,
    input  logic                 payoff_kind,
    input  logic [31:0]          up_f,
    input  logic [31:0]          down_f,
    input  logic [30:0]          prob,
    input  logic [30:0]          disc,
    output logic [31:0]          root_value,
    output logic                 clip
);

    logic [31:0] spot_reg;
    logic [31:0] strike_reg;
    logic        kind_reg;
    logic [31:0] price_reg;
    logic        clip_reg;
    logic [63:0] prod_reg;
    logic [62:0] mix_reg;
    logic [31:0] rd_data;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [30:0] p_eff;
    logic [30:0] q_eff;
    logic [30:0] d_eff;
    logic [33:0] scaled;
    logic [31:0] payoff;
    logic [31:0] ram_wdata;
    logic [32:0] mix_q;

    // clamp probability and discount to one
    assign p_eff = ({1'b0, prob} > btop_pkg::Q30_ONE) ? btop_pkg::Q30_ONE[30:0] : prob;
    assign q_eff = btop_pkg::Q30_ONE[30:0] - p_eff;
    assign d_eff = ({1'b0, disc} > btop_pkg::Q30_ONE) ? btop_pkg::Q30_ONE[30:0] : disc;

    // multiplier operand select
    always_comb
    begin
        ma = price_reg;
        mb = 32'd0;
        case (cmd.op)
            btop_pkg::OP_DOWN:  mb = down_f;
            btop_pkg::OP_UP:    mb = up_f;
            btop_pkg::OP_MIX_P:
            begin
                ma = rd_data;
                mb = {1'b0, p_eff};
            end
            btop_pkg::OP_MIX_Q:
            begin
                ma = rd_data;
                mb = {1'b0, q_eff};
            end
            btop_pkg::OP_DISC:
            begin
                ma = mix_q[31:0];
                mb = {1'b0, d_eff};
            end
            default: mb = 32'd0;
        endcase
    end

    // rounded q30 product of the registered multiply
    assign scaled = 34'((prod_reg + 64'(btop_pkg::Q30_ONE >> 1)) >> 30);
    assign mix_q  = 33'((mix_reg + 63'(btop_pkg::Q30_ONE >> 1)) >> 30);

    // payoff of current node price
    always_comb
    begin
        if (price_reg <= strike_reg)
        begin
            payoff = 32'd0;
        end
        else if (kind_reg)
        begin
            payoff = btop_pkg::Q16_ONE;
        end
        else
        begin
            payoff = price_reg - strike_reg;
        end
    end

    // folded value or payoff into the node store
    assign ram_wdata = cmd.fold_wr ? ((scaled > 34'(btop_pkg::PRICE_MAX)) ?
                       btop_pkg::PRICE_MAX : scaled[31:0]) : payoff;

    btop_ram #(.WIDTH(32), .DEPTH(MAX_STEPS + 1)) u_nodes (
        .clk     (clk),
        .wr_en   (cmd.payoff_wr | cmd.fold_wr),
        .wr_addr (wr_addr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // datapath registers
    always_ff @(posedge clk)
    begin
        // product holds until the next multiply is issued
        if (cmd.op != btop_pkg::OP_IDLE)
        begin
            prod_reg <= ma * mb;
        end
        if (cmd.load_item)
        begin
            spot_reg   <= spot_price;
            strike_reg <= strike_price;
            kind_reg   <= payoff_kind;
            clip_reg   <= 1'b0;
        end
        if (cmd.load_price)
        begin
            price_reg <= spot_reg;
        end
        else if (cmd.price_wr)
        begin
            if (scaled > 34'(btop_pkg::PRICE_MAX))
            begin
                price_reg <= btop_pkg::PRICE_MAX;
                clip_reg  <= 1'b1;
            end
            else
            begin
                price_reg <= scaled[31:0];
            end
        end
        if (cmd.op == btop_pkg::OP_MIX_Q)
        begin
            // p term product sits in prod_reg now
            mix_reg <= prod_reg[62:0];
        end
        else if (cmd.mix_add)
        begin
            // q term product sits in prod_reg now
            mix_reg <= mix_reg + prod_reg[62:0];
        end
        if (cmd.done)
        begin
            root_value <= rd_data;
        end
    end

    assign clip = clip_reg;

endmodule

FILE: src/btop_ctrl.sv
// btop_ctrl: sequencer for terminal node build and backward induction
// depends on btop_pkg
`timescale 1ns / 1ps

module btop_ctrl #(
    parameter int MAX_STEPS = 64,
    localparam int AW = $clog2(MAX_STEPS + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  logic [6:0]          step_count,
    output btop_pkg::btop_cmd_t cmd,
    output logic [AW-1:0]       wr_addr,
    output logic [AW-1:0]       rd_addr
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_WAIT,
        S_UPD,
        S_PAY,
        S_RDA,
        S_RDB,
        S_MP,
        S_MQ,
        S_DSC,
        S_DWAIT,
        S_FOLD,
        S_RRD,
        S_RWAIT,
        S_DONE
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] n_reg;
    logic [AW-1:0] i_reg;
    logic [AW-1:0] j_reg;
    logic [AW-1:0] t_reg;
    logic          out_valid_reg;
    logic [AW-1:0] n_eff;

    // step count limited to the store depth
    assign n_eff = (32'(step_count) > MAX_STEPS) ? AW'(MAX_STEPS) : AW'(step_count);

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;

    // command decode
    always_comb
    begin
        cmd = '0;
        cmd.op = btop_pkg::OP_IDLE;
        wr_addr = i_reg;
        rd_addr = i_reg;
        case (state_reg)
            S_IDLE:  cmd.load_item = in_valid && !out_valid_reg;
            S_START: cmd.load_price = 1'b1;
            S_MUL:   cmd.op = (j_reg < i_reg) ? btop_pkg::OP_DOWN : btop_pkg::OP_UP;
            S_UPD:   cmd.price_wr = 1'b1;
            S_PAY:   cmd.payoff_wr = 1'b1;
            S_RDA:   cmd.rd_en = 1'b1;
            S_RDB:
            begin
                // lower node is on the read port, upper node read next
                cmd.rd_en = 1'b1;
                cmd.op = btop_pkg::OP_MIX_P;
                rd_addr = i_reg + AW'(1);
            end
            S_MP:    cmd.op = btop_pkg::OP_MIX_Q;
            S_MQ:    cmd.mix_add = 1'b1;
            S_DSC:   cmd.op = btop_pkg::OP_DISC;
            S_FOLD:  cmd.fold_wr = 1'b1;
            S_RRD:
            begin
                cmd.rd_en = 1'b1;
                rd_addr = '0;
            end
            S_RWAIT: cmd.done = 1'b1;
            default: cmd = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            t_reg         <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !out_valid_reg)
                    begin
                        n_reg     <= n_eff;
                        i_reg     <= '0;
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    j_reg     <= '0;
                    state_reg <= (n_reg == '0) ? S_PAY : S_MUL;
                end
                S_MUL:   state_reg <= S_WAIT;
                S_WAIT:  state_reg <= S_UPD;
                S_UPD:
                begin
                    j_reg     <= j_reg + AW'(1);
                    state_reg <= (j_reg + AW'(1) == n_reg) ? S_PAY : S_MUL;
                end
                S_PAY:
                begin
                    if (i_reg == n_reg)
                    begin
                        i_reg     <= '0;
                        t_reg     <= n_reg;
                        state_reg <= (n_reg == '0) ? S_RRD : S_RDA;
                    end
                    else
                    begin
                        i_reg     <= i_reg + AW'(1);
                        state_reg <= S_START;
                    end
                end
                S_RDA:   state_reg <= S_RDB;
                S_RDB:   state_reg <= S_MP;
                S_MP:    state_reg <= S_MQ;
                S_MQ:    state_reg <= S_DSC;
                S_DSC:   state_reg <= S_DWAIT;
                S_DWAIT: state_reg <= S_FOLD;
                S_FOLD:
                begin
                    if (i_reg + AW'(1) == t_reg)
                    begin
                        i_reg <= '0;
                        t_reg <= t_reg - AW'(1);
                        state_reg <= (t_reg == AW'(1)) ? S_RRD : S_RDA;
                    end
                    else
                    begin
                        i_reg     <= i_reg + AW'(1);
                        state_reg <= S_RDA;
                    end
                end
                S_RRD:   state_reg <= S_RWAIT;
                S_RWAIT: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/binomial_tree_option_pricer.sv
// binomial_tree_option_pricer: top level, config registers, controller and datapath
// depends on btop_pkg, btop_ctrl, btop_dp
`timescale 1ns / 1ps
//
//  channel  | signals                                       | direction
//  input    | in_valid, in_stall, spot/strike/payoff_kind   | in
//  output   | out_valid, out_stall, option_value, saturated | out
//  config   | cfg_wr_en, cfg_index, cfg_data                | in
//
// for n steps, an item first builds n+1 terminal node prices, each by n multiplies on the
// single shared multiplier, then folds the tree back to the root, each fold using three multiplies
// one item at a time; input is stalled from acceptance until its result is taken
// reset clears control and configuration; the node store needs no clearing

module binomial_tree_option_pricer #(
    parameter int MAX_STEPS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] spot_price,
    input  logic [31:0] strike_price,
    input  logic        payoff_kind,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] option_value,
    output logic        saturated
);

    localparam int AW = $clog2(MAX_STEPS + 1);

    logic [31:0]         up_factor_reg;
    logic [31:0]         down_factor_reg;
    logic [30:0]         up_probability_reg;
    logic [30:0]         step_discount_reg;
    logic [6:0]          step_count_reg;
    btop_pkg::btop_cmd_t cmd;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [31:0]         root_value;
    logic                clip;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_factor_reg      <= btop_pkg::Q30_ONE;
            down_factor_reg    <= btop_pkg::Q30_ONE;
            up_probability_reg <= 31'h2000_0000;
            step_discount_reg  <= btop_pkg::Q30_ONE[30:0];
            step_count_reg     <= 7'd64;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                btop_pkg::REG_UP:   up_factor_reg      <= cfg_data;
                btop_pkg::REG_DOWN: down_factor_reg    <= cfg_data;
                btop_pkg::REG_PROB: up_probability_reg <= cfg_data[30:0];
                btop_pkg::REG_DISC: step_discount_reg  <= cfg_data[30:0];
                btop_pkg::REG_STEP: step_count_reg     <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    btop_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .step_count (step_count_reg),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr)
    );

    btop_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr),
        .spot_price   (spot_price),
        .strike_price (strike_price),
        .payoff_kind  (payoff_kind),
        .up_f         (up_factor_reg),
        .down_f       (down_factor_reg),
        .prob         (up_probability_reg),
        .disc         (step_discount_reg),
        .root_value   (root_value),
        .clip         (clip)
    );

    // result held stable while out_valid is up
    assign option_value = root_value;
    assign saturated    = clip;

endmodule

FILE: test/testbench.sv
// testbench for binomial_tree_option_pricer: directed table then random items,
// results checked against a behavioral tree pricer; depends on btop_pkg and the rtl
`timescale 1ns / 1ps

module testbench;

    localparam int MAXN = 64;
    localparam int WATCHDOG = 200000;

    typedef struct {
        logic [31:0] spot;
        logic [31:0] strike;
        logic        kind;
        bit          typed;
        logic [31:0] value;
        logic        sat;
    } stim_row_t;

    typedef struct {
        logic [31:0] value;
        logic        sat;
    } price_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] spot_price = '0;
    logic [31:0] strike_price = '0;
    logic        payoff_kind = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] option_value;
    logic        saturated;

    // model copy of the configuration
    logic [31:0] m_up = btop_pkg::Q30_ONE;
    logic [31:0] m_down = btop_pkg::Q30_ONE;
    logic [30:0] m_prob = 31'h2000_0000;
    logic [30:0] m_disc = btop_pkg::Q30_ONE[30:0];
    logic [6:0]  m_steps = 7'd64;

    price_t pending_prices[$];
    int errors = 0;
    int idle_cycles = 0;
    bit quiet_out = 1'b0;

    binomial_tree_option_pricer u_top (.*);

    always #5 clk = ~clk;

    // price times factor, rounded half up, clipped at the price ceiling
    function automatic logic [31:0] scale_by(logic [31:0] x, logic [31:0] f, ref bit clip);
        logic [63:0] prod;
        prod = (64'(x) * 64'(f) + 64'h2000_0000) >> 30;
        if (prod > 64'hFFFF_FFFF)
        begin
            clip = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return prod[31:0];
    endfunction

    function automatic price_t price_option(logic [31:0] s0, logic [31:0] k, logic kind);
        logic [31:0] node [0:MAXN];
        logic [31:0] px;
        logic [63:0] mix, v, p, q, dsc;
        int n;
        bit clip;
        price_t r;
        clip = 1'b0;
        n = (int'(m_steps) > MAXN) ? MAXN : int'(m_steps);
        p = ({1'b0, m_prob} > btop_pkg::Q30_ONE) ? 64'(btop_pkg::Q30_ONE) : 64'(m_prob);
        q = 64'(btop_pkg::Q30_ONE) - p;
        dsc = ({1'b0, m_disc} > btop_pkg::Q30_ONE) ? 64'(btop_pkg::Q30_ONE) : 64'(m_disc);
        // terminal payoffs
        for (int i = 0; i <= n; i++)
        begin
            px = s0;
            for (int j = 0; j < i; j++)
                px = scale_by(px, m_down, clip);
            for (int j = i; j < n; j++)
                px = scale_by(px, m_up, clip);
            node[i] = (px <= k) ? 32'd0 : (kind ? btop_pkg::Q16_ONE : px - k);
        end
        // backward induction
        for (int t = n; t > 0; t--)
            for (int i = 0; i < t; i++)
            begin
                mix = (p * node[i] + q * node[i+1] + 64'h2000_0000) >> 30;
                v = (dsc * mix + 64'h2000_0000) >> 30;
                node[i] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
            end
        r.value = node[0];
        r.sat = clip;
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            btop_pkg::REG_UP:   m_up = data;
            btop_pkg::REG_DOWN: m_down = data;
            btop_pkg::REG_PROB: m_prob = data[30:0];
            btop_pkg::REG_DISC: m_disc = data[30:0];
            btop_pkg::REG_STEP: m_steps = data[6:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every result is back, then a quiet gap
    task automatic drain;
        wait (pending_prices.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_item(logic [31:0] s, logic [31:0] k, logic kind, bit typed,
                             logic [31:0] val, logic sat);
        price_t e;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 3);
        repeat (gap) @(posedge clk);
        e = price_option(s, k, kind);
        if (typed)
        begin
            if (e.value !== val || e.sat !== sat)
            begin
                $error("table row disagrees with predictor: %h/%b vs %h/%b",
                       val, sat, e.value, e.sat);
                errors++;
            end
        end
        in_valid <= 1'b1;
        spot_price <= s;
        strike_price <= k;
        payoff_kind <= kind;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_prices.push_back(e);
        in_valid <= 1'b0;
    endtask

    task automatic random_config;
        logic [31:0] u;
        u = 32'h4000_0000 + $urandom_range(0, 32'h0400_0000);
        write_reg(btop_pkg::REG_UP, u);
        write_reg(btop_pkg::REG_DOWN, $urandom_range(32'h3800_0000, 32'h4000_0000));
        write_reg(btop_pkg::REG_PROB, $urandom_range(0, btop_pkg::Q30_ONE));
        write_reg(btop_pkg::REG_DISC, $urandom_range(32'h3F00_0000, btop_pkg::Q30_ONE));
        write_reg(btop_pkg::REG_STEP, $urandom_range(0, 12));
    endtask

    // result checking and output stall
    always @(posedge clk)
    begin
        price_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_prices.size() == 0)
                begin
                    $error("option_value %h with no item outstanding", option_value);
                    errors++;
                end
                else
                begin
                    e = pending_prices.pop_front();
                    if (option_value !== e.value)
                    begin
                        $error("option_value expected %h actual %h", e.value, option_value);
                        errors++;
                    end
                    if (saturated !== e.sat)
                    begin
                        $error("saturated expected %b actual %b", e.sat, saturated);
                        errors++;
                    end
                end
            end
            if (quiet_out)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 3) == 0) ?
                             ($urandom_range(0, 19) != 0) : 1'b0;
        end
    end

    // watchdog on cycles without any accepted item or taken result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    stim_row_t table_rows[$];

    initial
    begin
        logic [31:0] s, k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: u=d=1, disc=1, so value is the payoff at S0
        table_rows.push_back('{32'h0005_0000, 32'h0003_0000, 1'b0, 1, 32'h0002_0000, 1'b0});
        table_rows.push_back('{32'h0005_0000, 32'h0003_0000, 1'b1, 1, btop_pkg::Q16_ONE,
                               1'b0});
        table_rows.push_back('{32'h0003_0000, 32'h0003_0000, 1'b0, 1, 32'd0, 1'b0});
        table_rows.push_back('{32'h0003_0000, 32'h0003_0000, 1'b1, 1, 32'd0, 1'b0});
        table_rows.push_back('{32'hFFFF_FFFF, 32'd0, 1'b0, 1, 32'hFFFF_FFFF, 1'b0});
        table_rows.push_back('{32'hFFFF_FFFF, 32'd0, 1'b1, 1, btop_pkg::Q16_ONE, 1'b0});
        table_rows.push_back('{32'd0, 32'hFFFF_FFFF, 1'b0, 1, 32'd0, 1'b0});
        table_rows.push_back('{32'd0, 32'd0, 1'b1, 1, 32'd0, 1'b0});
        foreach (table_rows[i])
            send_item(table_rows[i].spot, table_rows[i].strike, table_rows[i].kind,
                      table_rows[i].typed, table_rows[i].value, table_rows[i].sat);
        drain();

        // zero steps, probability and discount above one, bad register index
        write_reg(btop_pkg::REG_STEP, 7'd0);
        write_reg(btop_pkg::REG_PROB, 32'h7FFF_FFFF);
        write_reg(btop_pkg::REG_DISC, 32'h7FFF_FFFF);
        write_reg(3'd7, 32'h0000_0001);
        write_reg(3'd5, 32'h1234_5678);
        send_item(32'h0008_0000, 32'h0002_0000, 1'b0, 1, 32'h0006_0000, 1'b0);
        drain();

        // steep up factor forces saturation; large step count above the maximum
        write_reg(btop_pkg::REG_UP, 32'hFFFF_FFFF);
        write_reg(btop_pkg::REG_DOWN, 32'd0);
        write_reg(btop_pkg::REG_PROB, 32'd0);
        write_reg(btop_pkg::REG_DISC, 32'd0);
        write_reg(btop_pkg::REG_STEP, 7'd127);
        send_item(32'hFFFF_FFFF, 32'd1, 1'b0, 0, '0, 1'b0);
        drain();
        write_reg(btop_pkg::REG_PROB, btop_pkg::Q30_ONE);
        write_reg(btop_pkg::REG_DISC, btop_pkg::Q30_ONE);
        write_reg(btop_pkg::REG_STEP, 7'd3);
        send_item(32'h8000_0000, 32'h0001_0000, 1'b0, 0, '0, 1'b0);
        send_item(32'h0001_0000, 32'h0000_8000, 1'b1, 0, '0, 1'b0);
        drain();
        write_reg(btop_pkg::REG_STEP, 7'd1);
        send_item(32'h0010_0000, 32'h000F_0000, 1'b0, 0, '0, 1'b0);
        drain();

        // random phases with realistic trees and some wide noise
        for (int ph = 0; ph < 6; ph++)
        begin
            random_config();
            for (int i = 0; i < 20; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    s = $urandom();
                    k = $urandom();
                end
                else
                begin
                    s = $urandom_range(32'h0001_0000, 32'h00FF_0000);
                    k = s + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                end
                send_item(s, k, 1'($urandom()), 0, '0, 1'b0);
                if (i == 10)
                    wait (pending_prices.size() == 0);
            end
            drain();
        end

        // one full-size tree with the output never stalled
        quiet_out = 1'b1;
        write_reg(btop_pkg::REG_STEP, 7'd64);
        write_reg(btop_pkg::REG_UP, 32'h4080_0000);
        write_reg(btop_pkg::REG_DOWN, 32'h3F80_0000);
        send_item(32'h0064_0000, 32'h0064_0000, 1'b0, 0, '0, 1'b0);
        drain();
        quiet_out = 1'b0;

        wait (pending_prices.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
